FILE: rtl/core/tmp_pkg.sv
`default_nettype none
package tmp_pkg;

  localparam int WORD_W = 32;
  localparam int FRAC_W = 24;

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  localparam logic [2:0] REG_START  = 3'd0;
  localparam logic [2:0] REG_TARGET = 3'd1;
  localparam logic [2:0] REG_VLIM   = 3'd2;
  localparam logic [2:0] REG_ALIM   = 3'd3;
  localparam logic [2:0] REG_DT     = 3'd4;

  localparam logic [1:0] PH_ACCEL  = 2'd0;
  localparam logic [1:0] PH_CRUISE = 2'd1;
  localparam logic [1:0] PH_DECEL  = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  typedef struct packed {
    logic       go;
    logic [1:0] op;
  } arith_cmd_t;

  function automatic logic [31:0] apply_dir(input logic negative, input logic [31:0] x);
    apply_dir = negative ? (32'd0 - x) : x;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/tmp_arith.sv
`default_nettype none
// shared bit-serial unit: 32x32 multiply, 64/32 divide, 64-bit square root
module tmp_arith (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tmp_pkg::arith_cmd_t cmd,
  input  wire logic [63:0]         a,
  input  wire logic [31:0]         b,
  output logic                     busy,
  output logic [63:0]              result
);

  logic        busy_r;
  logic [1:0]  op_r;
  logic [6:0]  cnt_r;
  logic [63:0] x_r;
  logic [63:0] y_r;
  logic [63:0] z_r;
  logic [35:0] rem_r;
  logic [31:0] b_r;

  logic [32:0] div_try;
  logic [35:0] sq_try;
  logic [35:0] sq_trial;

  assign div_try  = {rem_r[31:0], y_r[63]};
  assign sq_try   = {rem_r[33:0], y_r[63:62]};
  assign sq_trial = {z_r[33:0], 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.go) begin
      busy_r <= 1'b1;
      op_r   <= cmd.op;
      b_r    <= b;
      rem_r  <= '0;
      z_r    <= '0;
      x_r    <= {32'd0, a[31:0]};
      if (cmd.op == tmp_pkg::OP_MUL) begin
        y_r   <= {32'd0, b};
        cnt_r <= 7'd32;
      end else if (cmd.op == tmp_pkg::OP_DIV) begin
        y_r   <= a;
        cnt_r <= 7'd64;
      end else begin
        y_r   <= a;
        cnt_r <= 7'd32;
      end
    end else if (busy_r) begin
      case (op_r)
        tmp_pkg::OP_MUL: begin
          if (y_r[0]) z_r <= z_r + x_r;
          x_r <= {x_r[62:0], 1'b0};
          y_r <= {1'b0, y_r[63:1]};
        end
        tmp_pkg::OP_DIV: begin
          if (div_try >= {1'b0, b_r}) begin
            rem_r <= {3'd0, div_try - {1'b0, b_r}};
            y_r   <= {y_r[62:0], 1'b1};
          end else begin
            rem_r <= {3'd0, div_try};
            y_r   <= {y_r[62:0], 1'b0};
          end
        end
        default: begin
          if (sq_try >= sq_trial) begin
            rem_r <= sq_try - sq_trial;
            z_r   <= {z_r[62:0], 1'b1};
          end else begin
            rem_r <= sq_try;
            z_r   <= {z_r[62:0], 1'b0};
          end
          y_r <= {y_r[61:0], 2'b00};
        end
      endcase
      cnt_r <= cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign result = (op_r == tmp_pkg::OP_DIV) ? y_r : z_r;

endmodule
`default_nettype wire

FILE: rtl/core/trapezoidal_motion_profile.sv
`default_nettype none
// Trapezoidal velocity profile generator, Q8.24. A transfer with restart set recomputes the
// profile (peak velocity, ramp, cruise and total time) and returns the start position; with
// restart clear it advances one time step and returns the commanded set-point. All multiplies,
// divides and square roots run on one shared bit-serial unit; a restart or a moving tick holds
// off new input until its operations are done, while a hold or finished tick needs none of them.
// The result waits in an output register so the next item can be taken while it is pending.
module trapezoidal_motion_profile (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // restart
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata,  // position, velocity, acceleration, total_duration
  output logic [1:0]        out_tuser,  // phase
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [31:0]  cfg_data
);

  localparam logic [4:0] S_IDLE = 5'd0,  S_R_MUL = 5'd1, S_R_SQRT = 5'd2, S_R_RAMP = 5'd3,
                         S_R_USED = 5'd4, S_R_CRU = 5'd5, S_R_END = 5'd6, S_T_A1 = 5'd7,
                         S_T_A2 = 5'd8, S_T_C1 = 5'd9, S_T_C2 = 5'd10, S_T_D1 = 5'd11,
                         S_T_D2 = 5'd12, S_T_D3 = 5'd13, S_T_D4 = 5'd14, S_T_D5 = 5'd15,
                         S_FIN = 5'd16, S_OUT = 5'd17;

  logic [31:0] start_r, target_r;
  logic [30:0] vlim_r, alim_r, dt_r;
  logic [31:0] elapsed_r, peak_r, ramp_r, cruise_r, move_r;
  logic        neg_r;
  logic [4:0]  state_r;
  logic [31:0] dist_r, vm_r;
  logic [63:0] sum_r;
  logic [31:0] res_pos_r, res_vel_r, res_acc_r;
  logic [1:0]  res_phase_r;
  logic        out_valid_r;
  logic [127:0] out_data_r;
  logic [1:0]  out_user_r;

  tmp_pkg::arith_cmd_t cmd_r;
  logic [63:0] arg_a_r;
  logic [31:0] arg_b_r;
  logic        busy;
  logic [63:0] result;

  tmp_arith u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd_r),
    .a      (arg_a_r),
    .b      (arg_b_r),
    .busy   (busy),
    .result (result)
  );

  logic [30:0] acc_eff, vmax_eff;
  logic [32:0] diff, diff_abs;
  logic [32:0] t_sum;
  logic [31:0] t_new;
  logic [32:0] rc_sum;
  logic [31:0] td;
  logic [31:0] vm_w;
  logic [31:0] root_c, vp_c;
  logic [31:0] q_sat;
  logic [31:0] used, rem_d;
  logic [33:0] tot;
  logic [38:0] loss;
  logic [65:0] pos_w, sum_dir;
  logic [31:0] pos_sat;
  logic        wait_done;
  logic        in_fire;

  assign acc_eff  = (alim_r == '0) ? 31'd1 : alim_r;
  assign vmax_eff = (vlim_r == '0) ? 31'd1 : vlim_r;
  assign diff     = {target_r[31], target_r} - {start_r[31], start_r};
  assign diff_abs = diff[32] ? (33'd0 - diff) : diff;
  assign t_sum    = {1'b0, elapsed_r} + {2'b00, dt_r};
  assign t_new    = t_sum[32] ? '1 : t_sum[31:0];
  assign rc_sum   = {1'b0, ramp_r} + {1'b0, cruise_r};
  assign td       = elapsed_r - ramp_r - cruise_r;
  assign vm_w     = (result[63:24] > {8'd0, peak_r}) ? peak_r : result[55:24];
  assign root_c   = (result[31:0] > {1'b0, vmax_eff}) ? {1'b0, vmax_eff} : result[31:0];
  assign vp_c     = (root_c == '0) ? 32'd1 : root_c;
  assign q_sat    = (result[63:32] != '0) ? '1 : result[31:0];
  assign used     = (result > {32'd0, dist_r}) ? dist_r : result[31:0];
  assign rem_d    = dist_r - used;
  assign tot      = {1'b0, ramp_r, 1'b0} + {2'b00, q_sat};
  assign loss     = result[63:25];
  assign sum_dir  = neg_r ? (66'd0 - {2'b00, sum_r}) : {2'b00, sum_r};
  assign pos_w    = {{34{start_r[31]}}, start_r} + sum_dir;
  // in range when the bits above the sign all match it
  assign pos_sat  = (pos_w[65:31] == '0 || pos_w[65:31] == '1) ? pos_w[31:0] :
                    (pos_w[65] ? 32'h8000_0000 : 32'h7fff_ffff);
  assign wait_done = !cmd_r.go && !busy;
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= '0;
      target_r  <= '0;
      vlim_r    <= 31'd16777216;
      alim_r    <= 31'd16777216;
      dt_r      <= 31'd33554;
    end else if (cfg_valid) begin
      case (cfg_addr)
        tmp_pkg::REG_START:  start_r  <= cfg_data;
        tmp_pkg::REG_TARGET: target_r <= cfg_data;
        tmp_pkg::REG_VLIM:   vlim_r   <= cfg_data[30:0];
        tmp_pkg::REG_ALIM:   alim_r   <= cfg_data[30:0];
        tmp_pkg::REG_DT:     dt_r     <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cmd_r     <= '0;
      elapsed_r <= '0;
      peak_r    <= '0;
      ramp_r    <= '0;
      cruise_r  <= '0;
      move_r    <= '0;
      neg_r     <= 1'b0;
    end else begin
      cmd_r.go <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            res_vel_r <= '0;
            res_acc_r <= '0;
            if (in_tdata[0]) begin
              neg_r     <= diff[32];
              elapsed_r <= '0;
              dist_r    <= diff_abs[31:0];
              if (diff == '0) begin
                peak_r      <= '0;
                ramp_r      <= '0;
                cruise_r    <= '0;
                move_r      <= '0;
                res_pos_r   <= start_r;
                res_phase_r <= tmp_pkg::PH_DONE;
                state_r     <= S_OUT;
              end else begin
                cmd_r   <= '{go: 1'b1, op: tmp_pkg::OP_MUL};
                arg_a_r <= {32'd0, diff_abs[31:0]};
                arg_b_r <= {1'b0, acc_eff};
                state_r <= S_R_MUL;
              end
            end else begin
              elapsed_r <= t_new;
              if (start_r == target_r) begin
                res_pos_r   <= start_r;
                res_phase_r <= tmp_pkg::PH_DONE;
                state_r     <= S_OUT;
              end else if (t_new < ramp_r) begin
                cmd_r   <= '{go: 1'b1, op: tmp_pkg::OP_MUL};
                arg_a_r <= {33'd0, acc_eff};
                arg_b_r <= t_new;
                state_r <= S_T_A1;
              end else if ({1'b0, t_new} < rc_sum) begin
                cmd_r   <= '{go: 1'b1, op: tmp_pkg::OP_MUL};
                arg_a_r <= {32'd0, peak_r};
                arg_b_r <= ramp_r;
                state_r <= S_T_C1;
              end else if (t_new < move_r) begin
                cmd_r   <= '{go: 1'b1, op: tmp_pkg::OP_MUL};
                arg_a_r <= {33'd0, acc_eff};
                arg_b_r <= t_new - ramp_r - cruise_r;
                state_r <= S_T_D1;
              end else begin
                res_pos_r   <= target_r;
                res_phase_r <= tmp_pkg::PH_DONE;
                state_r     <= S_OUT;
              end
            end
          end
        end
        S_R_MUL: if (wait_done) begin
          cmd_r   <= '{go: 1'b1, op: tmp_pkg::OP_SQRT};
          arg_a_r <= result;
          state_r <= S_R_SQRT;
        end
        S_R_SQRT: if (wait_done) begin
          peak_r  <= vp_c;
          cmd_r   <= '{go: 1'b1, op: tmp_pkg::OP_DIV};
          arg_a_r <= {8'd0, vp_c, 24'd0};
          arg_b_r <= {1'b0, acc_eff};
          state_r <= S_R_RAMP;
        end
        S_R_RAMP: if (wait_done) begin
          ramp_r  <= q_sat;
          cmd_r   <= '{go: 1'b1, op: tmp_pkg::OP_MUL};
          arg_a_r <= {32'd0, peak_r};
          arg_b_r <= peak_r;
          state_r <= S_R_USED;
        end
        S_R_USED: if (wait_done) begin
          cmd_r   <= '{go: 1'b1, op: tmp_pkg::OP_DIV};
          arg_a_r <= result;
          arg_b_r <= {1'b0, acc_eff};
          state_r <= S_R_CRU;
        end
        S_R_CRU: if (wait_done) begin
          cmd_r   <= '{go: 1'b1, op: tmp_pkg::OP_DIV};
          arg_a_r <= {8'd0, rem_d, 24'd0};
          arg_b_r <= peak_r;
          state_r <= S_R_END;
        end
        S_R_END: if (wait_done) begin
          cruise_r    <= q_sat;
          move_r      <= (tot[33:32] != 2'b00) ? '1 : tot[31:0];
          res_pos_r   <= start_r;
          res_phase_r <= tmp_pkg::PH_ACCEL;
          state_r     <= S_OUT;
        end
        S_T_A1: if (wait_done) begin
          vm_r    <= vm_w;
          cmd_r   <= '{go: 1'b1, op: tmp_pkg::OP_MUL};
          arg_a_r <= {32'd0, vm_w};
          arg_b_r <= elapsed_r;
          state_r <= S_T_A2;
        end
        S_T_A2: if (wait_done) begin
          sum_r       <= {25'd0, result[63:25]};
          res_vel_r   <= tmp_pkg::apply_dir(neg_r, vm_r);
          res_acc_r   <= tmp_pkg::apply_dir(neg_r, {1'b0, acc_eff});
          res_phase_r <= tmp_pkg::PH_ACCEL;
          state_r     <= S_FIN;
        end
        S_T_C1: if (wait_done) begin
          sum_r   <= {25'd0, result[63:25]};
          cmd_r   <= '{go: 1'b1, op: tmp_pkg::OP_MUL};
          arg_a_r <= {32'd0, peak_r};
          arg_b_r <= elapsed_r - ramp_r;
          state_r <= S_T_C2;
        end
        S_T_C2: if (wait_done) begin
          sum_r       <= sum_r + {24'd0, result[63:24]};
          res_vel_r   <= tmp_pkg::apply_dir(neg_r, peak_r);
          res_phase_r <= tmp_pkg::PH_CRUISE;
          state_r     <= S_FIN;
        end
        S_T_D1: if (wait_done) begin
          vm_r    <= vm_w;
          cmd_r   <= '{go: 1'b1, op: tmp_pkg::OP_MUL};
          arg_a_r <= {32'd0, peak_r};
          arg_b_r <= ramp_r;
          state_r <= S_T_D2;
        end
        S_T_D2: if (wait_done) begin
          sum_r   <= {25'd0, result[63:25]};
          cmd_r   <= '{go: 1'b1, op: tmp_pkg::OP_MUL};
          arg_a_r <= {32'd0, peak_r};
          arg_b_r <= cruise_r;
          state_r <= S_T_D3;
        end
        S_T_D3: if (wait_done) begin
          sum_r   <= sum_r + {24'd0, result[63:24]};
          cmd_r   <= '{go: 1'b1, op: tmp_pkg::OP_MUL};
          arg_a_r <= {32'd0, peak_r};
          arg_b_r <= td;
          state_r <= S_T_D4;
        end
        S_T_D4: if (wait_done) begin
          sum_r   <= sum_r + {24'd0, result[63:24]};
          cmd_r   <= '{go: 1'b1, op: tmp_pkg::OP_MUL};
          arg_a_r <= {32'd0, vm_r};
          arg_b_r <= td;
          state_r <= S_T_D5;
        end
        S_T_D5: if (wait_done) begin
          sum_r       <= (sum_r > {25'd0, loss}) ? (sum_r - {25'd0, loss}) : '0;
          res_vel_r   <= tmp_pkg::apply_dir(neg_r, peak_r - vm_r);
          res_acc_r   <= tmp_pkg::apply_dir(!neg_r, {1'b0, acc_eff});
          res_phase_r <= tmp_pkg::PH_DECEL;
          state_r     <= S_FIN;
        end
        S_FIN: begin
          res_pos_r <= pos_sat;
          state_r   <= S_OUT;
        end
        S_OUT: if (!out_valid_r || out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // output register: loads once the previous result has been taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
      out_data_r  <= {move_r, res_acc_r, res_vel_r, res_pos_r};
      out_user_r  <= res_phase_r;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

FILE: dv/profile_checker.sv
`timescale 1ns / 1ps
module profile_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [7:0]   in_tdata,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [127:0] out_tdata,
  input  wire logic [1:0]   out_tuser,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_ready,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [31:0]  cfg_data,
  output int                fails,
  output int                pending
);

  typedef struct packed {
    logic [31:0] position;
    logic [31:0] velocity;
    logic [31:0] acceleration;
    logic [1:0]  phase;
    logic [31:0] total_duration;
  } setpoint_t;

  localparam longint unsigned WORD_MAX = 64'hFFFF_FFFF;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;

  logic [31:0] start_q, target_q;
  logic [30:0] vlim_q, alim_q, dt_q;
  longint unsigned elapsed, vpeak, t_ramp, t_cruise, t_move;
  logic negative;

  setpoint_t setpoint_q[$];

  assign pending = setpoint_q.size();

  function automatic longint unsigned root_floor(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned sat_word(input longint unsigned v);
    return (v > WORD_MAX) ? WORD_MAX : v;
  endfunction

  function automatic logic [31:0] sat_pos(input longint v);
    longint c;
    c = (v > POS_MAX) ? POS_MAX : ((v < POS_MIN) ? POS_MIN : v);
    return c[31:0];
  endfunction

  function automatic setpoint_t next_setpoint(input logic restart);
    setpoint_t sp;
    longint start, target, dir, pos, vel, acc_out;
    longint unsigned acc, span, vmax, vp, used, t, td, vm, gain, loss;
    start = longint'(signed'(start_q));
    target = longint'(signed'(target_q));
    acc = (alim_q == 0) ? 1 : alim_q;
    vel = 0;
    acc_out = 0;
    if (restart) begin
      span = (target > start) ? longint'(target - start) : longint'(start - target);
      vmax = (vlim_q == 0) ? 1 : vlim_q;
      negative = target < start;
      elapsed = 0;
      if (span == 0) begin
        vpeak = 0; t_ramp = 0; t_cruise = 0; t_move = 0;
        sp.phase = tmp_pkg::PH_DONE;
      end else begin
        vp = root_floor(acc * span);
        if (vp > vmax) vp = vmax;
        if (vp == 0) vp = 1;
        vpeak = vp;
        t_ramp = sat_word((vp << tmp_pkg::FRAC_W) / acc);
        used = (vp * vp) / acc;
        if (used > span) used = span;
        t_cruise = sat_word(((span - used) << tmp_pkg::FRAC_W) / vp);
        t_move = sat_word(2 * t_ramp + t_cruise);
        sp.phase = tmp_pkg::PH_ACCEL;
      end
      pos = start;
    end else begin
      t = sat_word(elapsed + dt_q);
      dir = negative ? -1 : 1;
      vp = vpeak;
      elapsed = t;
      if (start == target) begin
        pos = start;
        sp.phase = tmp_pkg::PH_DONE;
      end else if (t < t_ramp) begin
        vm = (acc * t) >> tmp_pkg::FRAC_W;
        if (vm > vp) vm = vp;
        span = (vm * t) >> (tmp_pkg::FRAC_W + 1);
        vel = dir * longint'(vm);
        acc_out = dir * longint'(acc);
        sp.phase = tmp_pkg::PH_ACCEL;
        pos = start + dir * longint'(span);
      end else if (t < t_ramp + t_cruise) begin
        span = ((vp * t_ramp) >> (tmp_pkg::FRAC_W + 1))
             + ((vp * (t - t_ramp)) >> tmp_pkg::FRAC_W);
        vel = dir * longint'(vp);
        sp.phase = tmp_pkg::PH_CRUISE;
        pos = start + dir * longint'(span);
      end else if (t < t_move) begin
        td = t - t_ramp - t_cruise;
        vm = (acc * td) >> tmp_pkg::FRAC_W;
        if (vm > vp) vm = vp;
        gain = ((vp * t_ramp) >> (tmp_pkg::FRAC_W + 1)) + ((vp * t_cruise) >> tmp_pkg::FRAC_W)
             + ((vp * td) >> tmp_pkg::FRAC_W);
        loss = (vm * td) >> (tmp_pkg::FRAC_W + 1);
        span = (gain > loss) ? gain - loss : 0;
        vel = dir * longint'(vp - vm);
        acc_out = -dir * longint'(acc);
        sp.phase = tmp_pkg::PH_DECEL;
        pos = start + dir * longint'(span);
      end else begin
        pos = target;
        sp.phase = tmp_pkg::PH_DONE;
      end
    end
    sp.position = sat_pos(pos);
    sp.velocity = sat_pos(vel);
    sp.acceleration = sat_pos(acc_out);
    sp.total_duration = t_move[31:0];
    return sp;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fails++;
      $display("%0t: %s expected %h actual %h", $realtime, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    setpoint_t sp;
    if (!rst_n) begin
      start_q <= '0;
      target_q <= '0;
      vlim_q <= 31'd16777216;
      alim_q <= 31'd16777216;
      dt_q <= 31'd33554;
      elapsed = 0; vpeak = 0; t_ramp = 0; t_cruise = 0; t_move = 0;
      negative = 1'b0;
      fails = 0;
      setpoint_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          tmp_pkg::REG_START:  start_q <= cfg_data;
          tmp_pkg::REG_TARGET: target_q <= cfg_data;
          tmp_pkg::REG_VLIM:   vlim_q <= cfg_data[30:0];
          tmp_pkg::REG_ALIM:   alim_q <= cfg_data[30:0];
          tmp_pkg::REG_DT:     dt_q <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) setpoint_q.push_back(next_setpoint(in_tdata[0]));
      if (out_tvalid && out_tready) begin
        if (setpoint_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected transfer, expected none actual %h phase %0d",
                   $realtime, out_tdata, out_tuser);
        end else begin
          sp = setpoint_q.pop_front();
          compare_field("position", sp.position, out_tdata[31:0]);
          compare_field("velocity", sp.velocity, out_tdata[63:32]);
          compare_field("acceleration", sp.acceleration, out_tdata[95:64]);
          compare_field("total_duration", sp.total_duration, out_tdata[127:96]);
          compare_field("phase", 32'(sp.phase), 32'(out_tuser));
        end
      end
    end
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int N_ITEMS = 1650;
  localparam int N_CALM = 150;
  localparam int STALL_LIMIT = 20000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;   // restart
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;       // position, velocity, acceleration, total_duration
  logic [1:0]   out_tuser;       // phase
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_addr = '0;
  logic [31:0]  cfg_data = '0;

  int fails, pending, sent, quiet_cnt;
  bit calm = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  trapezoidal_motion_profile dut (.*);

  profile_checker checker_i (.*);

  // receiver stalls in bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (calm) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  task automatic send_item(input bit restart);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'b0, restart};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic settle;
    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic load_profile(input logic [31:0] s, input logic [31:0] t,
                              input logic [30:0] v, input logic [30:0] a,
                              input logic [30:0] dt);
    settle();
    write_reg(tmp_pkg::REG_START, s);
    write_reg(tmp_pkg::REG_TARGET, t);
    write_reg(tmp_pkg::REG_VLIM, {1'b0, v});
    write_reg(tmp_pkg::REG_ALIM, {1'b0, a});
    write_reg(tmp_pkg::REG_DT, {1'b0, dt});
    cfg_valid <= 1'b0;
  endtask

  // time step so that the move spans about ticks steps
  function automatic logic [30:0] step_for(input logic [31:0] s, input logic [31:0] t,
                                           input logic [30:0] v, input logic [30:0] a,
                                           input int ticks);
    real d, av, vv, vp, tot, st;
    d = $itor(signed'(t)) - $itor(signed'(s));
    if (d < 0) d = -d;
    av = (a == 0) ? 1.0 : $itor(a);
    vv = (v == 0) ? 1.0 : $itor(v);
    if (d == 0) return 31'd1000;
    vp = $sqrt(av * d);
    if (vp > vv) vp = vv;
    if (vp < 1) vp = 1;
    tot = (2.0 * vp / av + (d - vp * vp / av) / vp) * 16777216.0;
    st = tot / ticks;
    if (st < 1) st = 1;
    if (st > 2147483647.0) st = 2147483647.0;
    return 31'($rtoi(st));
  endfunction

  task automatic run_move(input int ticks);
    send_item(1'b1);
    repeat (ticks) send_item(1'b0);
  endtask

  initial begin
    logic [31:0] s, t;
    logic [30:0] v, a, dt;
    int ticks;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hold at reset defaults, then zero time step
    run_move(2);
    load_profile(32'h0100_0000, 32'h0100_0000, 31'h0100_0000, 31'h0100_0000, 31'd0);
    run_move(2);
    // full-range moves both ways, with zero and with largest limits, and the largest step
    load_profile(32'h8000_0000, 32'h7FFF_FFFF, 31'd0, 31'd0, 31'h7FFF_FFFF);
    run_move(3);
    load_profile(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    run_move(3);
    // short negative move through acceleration into the start of cruise
    load_profile(32'h0200_0000, 32'h0000_0000, 31'h0080_0000, 31'h0100_0000,
                 31'h0010_0000);
    run_move(8);
    // live target change without restart
    load_profile(32'h0200_0000, 32'hFF00_0000, 31'h0080_0000, 31'h0200_0000,
                 31'h0010_0000);
    repeat (3) send_item(1'b0);

    while (sent < N_ITEMS) begin
      if (sent > N_ITEMS - N_CALM) calm = 1'b1;
      s = $urandom;
      case ($urandom_range(0, 5))
        0: t = s;
        1: t = $urandom;
        default: t = s + 32'(signed'($urandom_range(0, 32'h0800_0000)) -
                             signed'(32'h0400_0000));
      endcase
      v = ($urandom_range(0, 9) == 0) ? 31'($urandom_range(0, 1)) : 31'($urandom >> $urandom_range(1, 20));
      a = ($urandom_range(0, 9) == 0) ? 31'h7FFF_FFFF : 31'($urandom >> $urandom_range(1, 20));
      ticks = $urandom_range(3, 30);
      dt = ($urandom_range(0, 4) == 0) ? 31'($urandom >> $urandom_range(1, 31))
                                        : step_for(s, t, v, a, ticks);
      load_profile(s, t, v, a, dt);
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 4)) send_item(1'b0);
      run_move(ticks + $urandom_range(0, 4));
    end

    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (300) @(posedge clk);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/tmp_pkg.sv
rtl/core/tmp_arith.sv
rtl/core/trapezoidal_motion_profile.sv
dv/profile_checker.sv
dv/tb_top.sv
